/* rtl/ort_pkg.sv */
// Package for the outstanding request table: widths, codes and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ort_pkg;
    localparam int TableEntries = 16;
    localparam int LineBytes    = 64;
    localparam int WordBytes    = 4;
    localparam int AddrBits     = 48;
    localparam int OffBits      = $clog2(LineBytes);
    localparam int LineBits     = AddrBits - OffBits;
    localparam int SlotBits     = $clog2(TableEntries);
    localparam int CountBits    = $clog2(TableEntries + 1);

    localparam logic [1:0] OP_REQ  = 2'd0;
    localparam logic [1:0] OP_RDRS = 2'd1;
    localparam logic [1:0] OP_WRRS = 2'd2;

    localparam logic [2:0] ST_ISSUED      = 3'd0;
    localparam logic [2:0] ST_BUSY        = 3'd1;
    localparam logic [2:0] ST_ALIASED     = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_PARTIAL     = 3'd4;
    localparam logic [2:0] ST_COMPLETED   = 3'd5;
    localparam logic [2:0] ST_NOMATCH     = 3'd6;

    localparam logic [3:0] K_LD     = 4'd0;
    localparam logic [3:0] K_IFETCH = 4'd1;
    localparam logic [3:0] K_RMWRD  = 4'd2;
    localparam logic [3:0] K_ST     = 4'd3;
    localparam logic [3:0] K_LL     = 4'd4;
    localparam logic [3:0] K_SC     = 4'd5;
    localparam logic [3:0] K_LOCKRD = 4'd6;
    localparam logic [3:0] K_LOCKWR = 4'd7;
    localparam logic [3:0] K_FLUSH  = 4'd8;

    localparam logic CFG_MAX_OUT = 1'b0;
    localparam logic CFG_SC_EN   = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] byte_address;
        logic [15:0] request_tag;
        logic        is_llsc;
        logic        is_locked_op;
        logic        is_write;
        logic        is_read;
        logic        is_inst_fetch;
        logic        store_check;
        logic        is_flush;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  kind;
        logic [15:0] done_tag;
        logic        line_locked;
    } t_out_word;

    typedef struct packed {
        logic [0:0] index;
        logic [4:0] data;
    } t_cfg_word;
endpackage
`default_nettype wire

/* rtl/ort_if.sv */
// Valid/ready channel interface carrying one payload word.
// No dependencies; the payload type is set by the parameter T.
`timescale 1ns / 1ps
`default_nettype none
interface ort_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/outstanding_request_table.sv */
// Outstanding request table top level.
// Pipeline: each accepted word goes through the input register, then the result
// register, where its result is held until the receiver takes it.
// Throughput: one word per cycle while the output is not stalled, with a parallel
// line compare over all entries.
// Reset: synchronous, active low; empties the table, drops the lock and
// sets max_outstanding to 16 and store_check_enable to 1.
`timescale 1ns / 1ps
`default_nettype none
module outstanding_request_table (
    input  wire i_clk,
    input  wire i_rst_n,
    ort_if.sink   in_ch,
    ort_if.sink   cfg_ch,
    ort_if.source out_ch
);
    import ort_pkg::*;

    logic [4:0]             r_max_out;
    logic                   r_sc_en;
    logic                   r_in_valid;
    t_in_word               r_in;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [TableEntries-1:0] r_valid;
    logic [TableEntries-1:0] r_wtab;
    logic [LineBits-1:0]     r_line [TableEntries];
    logic [3:0]              r_kind [TableEntries];
    logic [15:0]             r_tag  [TableEntries];
    logic [LineBytes-1:0]    r_pend [TableEntries];
    logic [CountBits-1:0]    r_count;
    logic                    r_lock;
    logic [LineBits-1:0]     r_lock_line;

    logic                    stall, adv;
    logic [3:0]              cls_kind;
    logic                    cls_ok;
    logic [LineBits-1:0]     line;
    logic [OffBits-1:0]      off;
    logic [TableEntries-1:0] hit;
    logic                    found;
    logic [SlotBits-1:0]     hit_idx, free_idx;
    logic                    free_ok;
    logic [LineBytes-1:0]    clr, pend_nx;
    t_out_word               n_out;
    t_out_word               n_res;
    logic                    do_alloc, do_upd, do_free;
    logic                    n_lock;
    logic [LineBits-1:0]     n_lock_line;

    assign stall        = r_out_valid && !out_ch.ready;
    assign adv          = r_in_valid && !stall;
    assign in_ch.ready  = !(r_in_valid && stall);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid   = r_out_valid;
    assign out_ch.payload = r_out;

    ort_classify u_cls (.i_word(r_in), .i_sc_en(r_sc_en), .o_kind(cls_kind),
        .o_valid(cls_ok));

    assign line = r_in.byte_address[AddrBits-1:OffBits];
    assign off  = r_in.byte_address[OffBits-1:0];

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        found    = 1'b0;
        free_ok  = 1'b0;
        for (int i = 0; i < TableEntries; i++) begin
            hit[i] = r_valid[i] && (r_line[i] == line);
            if (hit[i]) begin
                found   = 1'b1;
                hit_idx = SlotBits'(i);
            end
        end
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = SlotBits'(i);
            end
        end
        for (int b = 0; b < LineBytes; b++) begin
            clr[b] = (b >= int'(off)) && (b < int'(off) + WordBytes);
        end
        pend_nx = r_pend[hit_idx] & ~clr;
    end

    always_comb begin
        n_out       = '0;
        n_out.status = ST_NOMATCH;
        do_alloc    = 1'b0;
        do_upd      = 1'b0;
        do_free     = 1'b0;
        unique case (r_in.operation)
            OP_REQ: begin
                n_out.kind = cls_kind;
                if ((r_count >= CountBits'(r_max_out)) || found ||
                    (r_count >= CountBits'(TableEntries)) || !free_ok)
                    n_out.status = ST_BUSY;
                else if (!cls_ok)
                    n_out.status = ST_UNSUPPORTED;
                else if (r_lock && r_lock_line == line && cls_kind != K_LOCKWR)
                    n_out.status = ST_ALIASED;
                else begin
                    n_out.status = ST_ISSUED;
                    do_alloc     = 1'b1;
                end
            end
            OP_RDRS, OP_WRRS: begin
                if (found && r_wtab[hit_idx] == (r_in.operation == OP_WRRS)) begin
                    n_out.kind = r_kind[hit_idx];
                    do_upd     = 1'b1;
                    if (pend_nx == '0) begin
                        do_free        = 1'b1;
                        n_out.status   = ST_COMPLETED;
                        n_out.done_tag = r_tag[hit_idx];
                    end else begin
                        n_out.status = ST_PARTIAL;
                    end
                end
            end
            default: n_out.kind = K_LD;
        endcase
    end

    always_comb begin
        n_lock      = r_lock;
        n_lock_line = r_lock_line;
        if (do_free && r_in.operation == OP_WRRS) begin
            if (n_out.kind == K_LOCKRD) begin
                n_lock      = 1'b1;
                n_lock_line = line;
            end else if (n_out.kind == K_LOCKWR && r_lock && r_lock_line == line) begin
                n_lock = 1'b0;
            end
        end
        n_res             = n_out;
        n_res.line_locked = n_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out   <= 5'd16;
            r_sc_en     <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_lock      <= 1'b0;
            r_lock_line <= '0;
        end else begin
            if (cfg_ch.valid) begin
                if (cfg_ch.payload.index == CFG_MAX_OUT)
                    r_max_out <= cfg_ch.payload.data;
                else
                    r_sc_en <= cfg_ch.payload.data[0];
            end
            if (in_ch.ready) r_in_valid <= in_ch.valid;
            if (!stall) r_out_valid <= r_in_valid;
            if (adv) begin
                r_lock      <= n_lock;
                r_lock_line <= n_lock_line;
                if (do_alloc) begin
                    r_valid[free_idx] <= 1'b1;
                    r_count <= r_count + 1'b1;
                end
                if (do_free) begin
                    r_valid[hit_idx] <= 1'b0;
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) r_in <= in_ch.payload;
        if (adv) begin
            r_out <= n_res;
            if (do_alloc) begin
                r_wtab[free_idx] <= !(cls_kind == K_LD || cls_kind == K_IFETCH);
                r_line[free_idx] <= line;
                r_kind[free_idx] <= cls_kind;
                r_tag[free_idx]  <= r_in.request_tag;
                r_pend[free_idx] <= '1;
            end
            if (do_upd) r_pend[hit_idx] <= pend_nx;
        end
    end
endmodule
`default_nettype wire

/* rtl/ort_classify.sv */
// Sorts a new request into one of nine kinds from its flags.
// Depends on ort_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ort_classify (
    input  wire ort_pkg::t_in_word i_word,
    input  wire                    i_sc_en,
    output logic [3:0]             o_kind,
    output logic                   o_valid
);
    import ort_pkg::*;
    always_comb begin
        o_valid = 1'b1;
        priority if (i_word.is_llsc) begin
            o_kind = i_word.is_write ? K_SC : K_LL;
        end else if (i_word.is_locked_op) begin
            o_kind = i_word.is_write ? K_LOCKWR : K_LOCKRD;
        end else if (i_word.is_write) begin
            o_kind = K_ST;
        end else if (i_word.is_read) begin
            if (i_word.is_inst_fetch) o_kind = K_IFETCH;
            else o_kind = (i_word.store_check && i_sc_en) ? K_RMWRD : K_LD;
        end else if (i_word.is_flush) begin
            o_kind = K_FLUSH;
        end else begin
            o_kind  = K_LD;
            o_valid = 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/ort_checker.sv */
// Port-level checker for the outstanding request table, bound to the top.
// Depends on ort_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ort_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire o_valid,
    input wire o_ready,
    input wire ort_pkg::t_out_word o_word
);
    import ort_pkg::*;
    a_tag_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status != ST_COMPLETED |-> o_word.done_tag == 16'd0)
        else $error("tag without completion");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word.status != 3'd7) else $error("bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_word))
        else $error("stalled word changed");
endmodule
bind outstanding_request_table ort_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_word(out_ch.payload));
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the outstanding request table.
// Depends on ort_pkg, ort_if and outstanding_request_table from the rtl folder.
`timescale 1ns / 1ps
module tb_top;
    import ort_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int PoolLines  = 12;

    logic i_clk;
    logic i_rst_n;

    ort_if #(.T(t_in_word))  in_if ();
    ort_if #(.T(t_cfg_word)) cfg_if ();
    ort_if #(.T(t_out_word)) out_if ();

    outstanding_request_table i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_if),
        .cfg_ch (cfg_if),
        .out_ch (out_if)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the table, the lock and the registers.
    logic                entry_valid [TableEntries];
    logic                entry_wtable[TableEntries];
    logic [LineBits-1:0] entry_line  [TableEntries];
    logic [3:0]          entry_kind  [TableEntries];
    logic [15:0]         entry_tag   [TableEntries];
    logic [LineBytes-1:0] entry_pend [TableEntries];
    int                  occupied;
    logic                lock_on;
    logic [LineBits-1:0] lock_at;
    logic [4:0]          max_out;
    logic                sc_en;

    t_out_word   pending_results[$];
    int          errors;
    int          cycles;
    logic [LineBits-1:0] line_pool[PoolLines];

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int classify(t_in_word w);
        if (w.is_llsc) return w.is_write ? K_SC : K_LL;
        if (w.is_locked_op) return w.is_write ? K_LOCKWR : K_LOCKRD;
        if (w.is_write) return K_ST;
        if (w.is_read) begin
            if (w.is_inst_fetch) return K_IFETCH;
            return (w.store_check && sc_en) ? K_RMWRD : K_LD;
        end
        if (w.is_flush) return K_FLUSH;
        return -1;
    endfunction

    function automatic int find_entry(logic [LineBits-1:0] ln);
        for (int i = 0; i < TableEntries; i++)
            if (entry_valid[i] && entry_line[i] == ln) return i;
        return -1;
    endfunction

    // Applies one accepted word to the shadow state and returns its result.
    function automatic t_out_word table_step(t_in_word w);
        t_out_word r;
        logic [LineBits-1:0] ln;
        int off, k, s, f, p;
        logic wr_rsp;
        ln = w.byte_address[AddrBits-1:OffBits];
        off = w.byte_address[OffBits-1:0];
        r.status = ST_NOMATCH;
        r.kind = K_LD;
        r.done_tag = '0;
        if (w.operation == OP_REQ) begin
            k = classify(w);
            s = find_entry(ln);
            r.kind = (k < 0) ? K_LD : 4'(k);
            if (occupied >= max_out || occupied >= TableEntries || s >= 0) begin
                r.status = ST_BUSY;
            end else if (k < 0) begin
                r.status = ST_UNSUPPORTED;
            end else if (lock_on && lock_at == ln && r.kind != K_LOCKWR) begin
                r.status = ST_ALIASED;
            end else begin
                f = -1;
                for (int i = 0; i < TableEntries; i++)
                    if (!entry_valid[i] && f < 0) f = i;
                if (f < 0) begin
                    r.status = ST_BUSY;
                end else begin
                    entry_valid[f] = 1'b1;
                    entry_wtable[f] = !(r.kind == K_LD || r.kind == K_IFETCH);
                    entry_line[f] = ln;
                    entry_kind[f] = r.kind;
                    entry_tag[f] = w.request_tag;
                    entry_pend[f] = '1;
                    occupied++;
                    r.status = ST_ISSUED;
                end
            end
        end else if (w.operation == OP_RDRS || w.operation == OP_WRRS) begin
            s = find_entry(ln);
            wr_rsp = (w.operation == OP_WRRS);
            if (s >= 0 && entry_wtable[s] == wr_rsp) begin
                r.kind = entry_kind[s];
                for (int b = 0; b < WordBytes; b++) begin
                    p = off + b;
                    if (p < LineBytes) entry_pend[s][p] = 1'b0;
                end
                if (entry_pend[s] == '0) begin
                    entry_valid[s] = 1'b0;
                    if (occupied > 0) occupied--;
                    r.done_tag = entry_tag[s];
                    r.status = ST_COMPLETED;
                    if (wr_rsp) begin
                        if (r.kind == K_LOCKRD) begin
                            lock_on = 1'b1;
                            lock_at = ln;
                        end else if (r.kind == K_LOCKWR && lock_on && lock_at == ln) begin
                            lock_on = 1'b0;
                        end
                    end
                end else begin
                    r.status = ST_PARTIAL;
                end
            end
        end
        r.line_locked = lock_on;
        return r;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Flags are {llsc, locked_op, write, read, inst_fetch, store_check, flush}.
    function automatic t_in_word make_word(logic [1:0] op, logic [47:0] addr,
                                           logic [15:0] tag, logic [6:0] fl);
        t_in_word w;
        w.operation = op;
        w.byte_address = addr;
        w.request_tag = tag;
        {w.is_llsc, w.is_locked_op, w.is_write, w.is_read,
         w.is_inst_fetch, w.store_check, w.is_flush} = fl;
        return w;
    endfunction

    function automatic logic [6:0] flags_for(int pick);
        case (pick)
            0: return 7'b0001000;
            1: return 7'b0001100;
            2: return 7'b0001010;
            3: return 7'b0010000;
            4: return 7'b1000000;
            5: return 7'b1010000;
            6: return 7'b0101000;
            7: return 7'b0110000;
            8: return 7'b0000001;
            default: return 7'b0000000;
        endcase
    endfunction

    function automatic t_in_word random_word();
        int r, live[$], s, w0, ww, off;
        logic [47:0] addr;
        logic [6:0] fl;
        r = $urandom_range(0, 99);
        for (int i = 0; i < TableEntries; i++)
            if (entry_valid[i]) live.push_back(i);
        if (r < 58 && live.size() > 0) begin
            s = live[$urandom_range(0, live.size() - 1)];
            off = $urandom_range(0, LineBytes - 1);
            if ($urandom_range(0, 99) < 88) begin
                w0 = $urandom_range(0, 15);
                for (int j = 0; j < 16; j++) begin
                    ww = (w0 + j) % 16;
                    if (entry_pend[s][ww*4 +: 4] != '0 && off % 4 != 0) off = ww * 4;
                    if (entry_pend[s][ww*4 +: 4] != '0) off = ww * 4;
                    if (entry_pend[s][ww*4 +: 4] != '0) break;
                end
            end
            return make_word(entry_wtable[s] ? OP_WRRS : OP_RDRS,
                             {entry_line[s], 6'(off)}, 16'($urandom), 7'($urandom));
        end
        if (r >= 92) begin
            // Noise: responses to nothing, the wrong table, or the unused operation.
            addr = {16'($urandom), 32'($urandom)};
            if ($urandom_range(0, 1)) addr[47:6] = line_pool[$urandom_range(0, PoolLines - 1)];
            return make_word(2'($urandom_range(1, 3)), addr, 16'($urandom), 7'($urandom));
        end
        if ($urandom_range(0, 9) == 0) addr = {16'($urandom), 32'($urandom)};
        else addr = {line_pool[$urandom_range(0, PoolLines - 1)], 6'($urandom)};
        fl = ($urandom_range(0, 7) == 0) ? 7'($urandom) : flags_for($urandom_range(0, 9));
        return make_word(OP_REQ, addr, 16'($urandom), fl);
    endfunction

    task automatic push_word(t_in_word w, bit typed, t_out_word want);
        int g;
        t_out_word pred;
        g = rand_gap();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= w;
        do @(posedge i_clk); while (!in_if.ready);
        pred = table_step(w);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        t_cfg_word c;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        c.index = idx;
        c.data = val;
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= c;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_MAX_OUT) max_out = val;
        else sc_en = val[0];
    endtask

    // Receiver stalls, with quiet stretches where it is always ready.
    int stall_left, quiet_left;
    always @(posedge i_clk) begin
        if (quiet_left > 0) begin
            quiet_left <= quiet_left - 1;
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 2) quiet_left <= $urandom_range(50, 200);
            else if ($urandom_range(0, 4) == 0) stall_left <= rand_gap();
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", out_if.payload.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (out_if.payload.status != want.status)
                    report("status", out_if.payload.status, want.status);
                if (out_if.payload.kind != want.kind)
                    report("kind", out_if.payload.kind, want.kind);
                if (out_if.payload.done_tag != want.done_tag)
                    report("done_tag", out_if.payload.done_tag, want.done_tag);
                if (out_if.payload.line_locked != want.line_locked)
                    report("line_locked", out_if.payload.line_locked, want.line_locked);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    typedef struct {
        t_in_word  stim;
        bit        typed;
        t_out_word want;
    } t_row;

    function automatic t_out_word res(logic [2:0] st, logic [3:0] k, logic [15:0] tg, logic lk);
        t_out_word r;
        r.status = st;
        r.kind = k;
        r.done_tag = tg;
        r.line_locked = lk;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_out_word none;
        logic [4:0] max_seq[6] = '{5'd1, 5'd16, 5'd0, 5'd4, 5'd31, 5'd16};
        logic       sc_seq[6]  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        none = res(ST_NOMATCH, K_LD, 16'h0, 1'b0);
        i_rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        stall_left = 0;
        quiet_left = 0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < TableEntries; i++) entry_valid[i] = 1'b0;
        occupied = 0;
        lock_on = 1'b0;
        lock_at = '0;
        max_out = 5'd16;
        sc_en = 1'b1;
        line_pool[0] = '0;
        line_pool[1] = '1;
        line_pool[2] = 42'h4;
        for (int i = 3; i < PoolLines; i++) line_pool[i] = {10'($urandom), 32'($urandom)};

        rows.push_back('{make_word(OP_RDRS, 48'h0, 16'h0, 7'h00), 1, none});
        rows.push_back('{make_word(2'd3, '1, '1, '1), 1, none});
        rows.push_back('{make_word(OP_REQ, '1, '1, 7'h00), 1,
                         res(ST_UNSUPPORTED, K_LD, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h0, 16'h0, flags_for(0)), 1,
                         res(ST_ISSUED, K_LD, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h3F, 16'h5, flags_for(3)), 1,
                         res(ST_BUSY, K_ST, 0, 0)});
        rows.push_back('{make_word(OP_WRRS, 48'h0, 16'h0, 7'h00), 1, none});
        // A word that runs past the end of the line clears only two bytes.
        rows.push_back('{make_word(OP_RDRS, 48'h3E, 16'h0, 7'h00), 1,
                         res(ST_PARTIAL, K_LD, 0, 0)});
        rows.push_back('{make_word(OP_REQ, '1, '1, flags_for(1)), 1,
                         res(ST_ISSUED, K_IFETCH, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h40, 16'h1, flags_for(2)), 1,
                         res(ST_ISSUED, K_RMWRD, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h80, 16'h2, flags_for(5)), 1,
                         res(ST_ISSUED, K_SC, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'hC0, 16'h3, flags_for(4)), 1,
                         res(ST_ISSUED, K_LL, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h100, 16'h1234, 7'b0100000), 1,
                         res(ST_ISSUED, K_LOCKRD, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h140, 16'h4, flags_for(8)), 1,
                         res(ST_ISSUED, K_FLUSH, 0, 0)});
        rows.push_back('{make_word(OP_REQ, 48'h180, 16'h6, 7'h7F), 1,
                         res(ST_ISSUED, K_SC, 0, 0)});
        for (int wd = 0; wd < 15; wd++)
            rows.push_back('{make_word(OP_WRRS, 48'h100 + 4 * wd, 16'h0, 7'h00), 0, none});
        rows.push_back('{make_word(OP_WRRS, 48'h13C, 16'h0, 7'h00), 1,
                         res(ST_COMPLETED, K_LOCKRD, 16'h1234, 1)});
        rows.push_back('{make_word(OP_REQ, 48'h104, 16'h7, flags_for(0)), 1,
                         res(ST_ALIASED, K_LD, 0, 1)});
        rows.push_back('{make_word(OP_REQ, 48'h100, 16'h8, flags_for(7)), 1,
                         res(ST_ISSUED, K_LOCKWR, 0, 1)});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) push_word(rows[i].stim, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            in_if.valid <= 1'b0;
            write_reg(CFG_MAX_OUT, max_seq[ph]);
            write_reg(CFG_SC_EN, {4'd0, sc_seq[ph]});
            // The refuse-all setting gets a short phase.
            for (int n = 0; n < ((max_seq[ph] == 0) ? 60 : 250); n++)
                push_word(random_word(), 0, none);
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/ort_pkg.sv
rtl/ort_if.sv
rtl/ort_classify.sv
rtl/outstanding_request_table.sv
rtl/ort_checker.sv
test/tb_top.sv
